FILE: rtl/core/srda_pkg.sv
// Shared types and constants for the session replay and duplicate admission filter.
`default_nettype none
package srda_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int SESSION_SLOTS_DEF = 8;
  localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    DISP_ACCEPTED        = 4'd0,
    DISP_DUP_PIXELS      = 4'd1,
    DISP_DUP_OBSERVATION = 4'd2,
    DISP_DUP_GEOMETRY    = 4'd3,
    DISP_DUP_CALIBRATION = 4'd4,
    DISP_CONFLICT        = 4'd5,
    DISP_STALE           = 4'd6,
    DISP_SESSION_LIMIT   = 4'd7,
    DISP_EXHAUSTED       = 4'd8,
    DISP_CLEARED         = 4'd9
  } disp_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCAN,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOK,
    B_APPLY
  } back_state_t;

  typedef struct packed {
    logic [63:0] tag;
    logic [31:0] seq;
    logic [63:0] codeword;
    logic [63:0] pixels;
    logic [31:0] geo_gen;
    logic [31:0] cal_gen;
  } hist_entry_t;

  typedef struct packed {
    logic        clear;
    logic [63:0] tag;
    logic [31:0] seq;
    logic [7:0]  profile;
    logic [63:0] codeword;
    logic [63:0] pixels;
    logic [63:0] geo;
    logic [63:0] cal;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic        found;
    hist_entry_t entry;
  } job_t;

  typedef struct packed {
    disp_t       disp;
    logic [31:0] geo_gen;
    logic [31:0] cal_gen;
    logic [3:0]  tracked;
    logic [6:0]  retained;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/srda_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/srda_front.sv
// Front end: accept an item and scan the history ring for its tag and sequence.
`default_nettype none
module srda_front #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire srda_pkg::item_t                  in_item,
  input  wire logic                             allow,
  input  wire logic [HISTORY_DEPTH-1:0]         hist_valid,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] ram_raddr,
  input  wire srda_pkg::hist_entry_t            ram_rdata,
  output logic                                  q_push,
  output srda_pkg::job_t                        q_job,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] q_idx,
  input  wire logic                             q_full
);
  import srda_pkg::*;

  localparam int IW = $clog2(HISTORY_DEPTH);
  localparam logic [IW-1:0] LAST = IW'(HISTORY_DEPTH - 1);

  front_state_t state_r, state_nxt;
  item_t        item_r;
  hist_entry_t  entry_r;
  logic [IW-1:0] addr_r, pidx_r, fidx_r;
  logic          issue_r, pend_r, found_r;
  logic          hit, accept;

  assign hit    = pend_r && hist_valid[pidx_r] && (ram_rdata.tag == item_r.tag) &&
                  (ram_rdata.seq == item_r.seq);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = in_item.clear ? F_PUSH : F_SCAN;
        end
      end
      F_SCAN: begin
        if (hit || (pend_r && pidx_r == LAST)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    q_push    = 1'b0;
    ram_raddr = addr_r;
    unique case (state_r)
      F_IDLE:  in_ready = allow;
      F_SCAN:  in_ready = 1'b0;
      F_PUSH:  q_push   = !q_full;
      default: in_ready = 1'b0;
    endcase
  end

  assign q_job = '{item: item_r, found: found_r, entry: entry_r};
  assign q_idx = fidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        issue_r <= !in_item.clear;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end else if (state_r == F_SCAN) begin
        issue_r <= issue_r && !hit && (addr_r != LAST);
        pend_r  <= issue_r && !hit;
        if (hit) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      addr_r <= '0;
    end else if (state_r == F_SCAN) begin
      if (issue_r) begin
        addr_r <= addr_r + 1'b1;
      end
      pidx_r <= addr_r;
      if (hit) begin
        fidx_r  <= pidx_r;
        entry_r <= ram_rdata;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/srda_queue.sv
// Two-entry queue of classified jobs between front and back.
`default_nettype none
module srda_queue #(
  parameter int IDX_W = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire srda_pkg::job_t       push_job,
  input  wire logic [IDX_W-1:0]     push_idx,
  output logic                      full,
  output logic                      empty,
  input  wire logic                 pop,
  output srda_pkg::job_t            pop_job,
  output logic      [IDX_W-1:0]     pop_idx
);
  import srda_pkg::*;

  job_t             job_q [2];
  logic [IDX_W-1:0] idx_q [2];
  logic             wr_r, rd_r;
  logic [1:0]       cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_job = job_q[rd_r];
  assign pop_idx = idx_q[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_r <= !wr_r;
      end
      if (pop && !empty) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      job_q[wr_r] <= push_job;
      idx_q[wr_r] <= push_idx;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/srda_back.sv
// Back end: session lookup, generation tracking, table updates and result register.
`default_nettype none
module srda_back #(
  parameter int HISTORY_DEPTH = 64,
  parameter int SESSION_SLOTS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_empty,
  output logic                                  q_pop,
  input  wire srda_pkg::job_t                   q_job,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0] q_idx,
  output logic                                  busy,
  output logic      [HISTORY_DEPTH-1:0]         hist_valid,
  output logic                                  ram_we,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] ram_waddr,
  output srda_pkg::hist_entry_t                 ram_wdata,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output srda_pkg::result_t                     out_result
);
  import srda_pkg::*;

  localparam int IW  = $clog2(HISTORY_DEPTH);
  localparam int SW  = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
  localparam int SCW = $clog2(SESSION_SLOTS + 1);
  localparam int RCW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IW-1:0]  LAST = IW'(HISTORY_DEPTH - 1);
  localparam logic [RCW-1:0] RMAX = RCW'(HISTORY_DEPTH);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [IW-1:0] idx_r, write_slot_r;
  logic [HISTORY_DEPTH-1:0] valid_r, conflict_r;
  logic [SESSION_SLOTS-1:0] sess_active_r;
  logic [63:0] sess_tag_r  [SESSION_SLOTS];
  logic [31:0] sess_high_r [SESSION_SLOTS];
  logic [7:0]  sess_prof_r [SESSION_SLOTS];
  logic        smatch_r, sfree_r, smatch, sfree;
  logic [SW-1:0] sidx_r, eidx_r, sidx, eidx;
  logic        geo_known_r, cal_known_r;
  logic [63:0] geo_held_r, cal_held_r;
  logic [31:0] geo_cnt_r, cal_cnt_r;
  logic [SCW-1:0] sess_cnt_r;
  logic [RCW-1:0] ret_cnt_r;
  logic        out_valid_r;
  result_t     out_r;

  logic        geo_ch, cal_ch, exhausted;
  logic [31:0] g1, c1;
  logic        do_clear, do_conf, do_commit, do_new, new_sess;
  disp_t       disp;
  result_t     res;

  assign hist_valid = valid_r;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;
  assign busy       = (state_r != B_IDLE);

  always_comb begin
    smatch = 1'b0;
    sfree  = 1'b0;
    sidx   = '0;
    eidx   = '0;
    for (int i = 0; i < SESSION_SLOTS; i++) begin
      if (sess_active_r[i] && sess_tag_r[i] == job_r.item.tag) begin
        smatch = 1'b1;
        sidx   = SW'(i);
      end
      if (!sess_active_r[i] && !sfree) begin
        sfree = 1'b1;
        eidx  = SW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty && !out_valid_r) begin
        state_nxt = B_LOOK;
      end
      B_LOOK:  state_nxt = B_APPLY;
      B_APPLY: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  assign geo_ch    = !geo_known_r || (geo_held_r != job_r.item.geo);
  assign cal_ch    = !cal_known_r || (cal_held_r != job_r.item.cal);
  assign exhausted = (geo_ch && geo_cnt_r == GEN_MAX) || (cal_ch && cal_cnt_r == GEN_MAX);
  assign g1        = geo_cnt_r + {31'd0, geo_ch};
  assign c1        = cal_cnt_r + {31'd0, cal_ch};

  always_comb begin
    q_pop     = 1'b0;
    do_clear  = 1'b0;
    do_conf   = 1'b0;
    do_commit = 1'b0;
    disp      = DISP_ACCEPTED;
    unique case (state_r)
      B_IDLE: q_pop = !q_empty && !out_valid_r;
      B_LOOK: q_pop = 1'b0;
      B_APPLY: begin
        if (job_r.item.clear) begin
          do_clear = 1'b1;
          disp     = DISP_CLEARED;
        end else if (job_r.found && (conflict_r[idx_r] ||
                     job_r.entry.codeword != job_r.item.codeword)) begin
          do_conf = 1'b1;
          disp    = DISP_CONFLICT;
        end else if (!smatch_r && !sfree_r) begin
          disp = DISP_SESSION_LIMIT;
        end else if (smatch_r && sess_prof_r[sidx_r] != job_r.item.profile) begin
          disp = DISP_CONFLICT;
        end else if (!job_r.found && smatch_r && job_r.item.seq <= sess_high_r[sidx_r]) begin
          disp = DISP_STALE;
        end else if (exhausted) begin
          disp = DISP_EXHAUSTED;
        end else begin
          do_commit = 1'b1;
          if (!job_r.found) begin
            disp = DISP_ACCEPTED;
          end else if (job_r.entry.geo_gen != g1) begin
            disp = DISP_DUP_GEOMETRY;
          end else if (job_r.entry.cal_gen != c1) begin
            disp = DISP_DUP_CALIBRATION;
          end else if (job_r.entry.pixels == job_r.item.pixels) begin
            disp = DISP_DUP_PIXELS;
          end else begin
            disp = DISP_DUP_OBSERVATION;
          end
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  assign do_new   = do_commit && !job_r.found;
  assign new_sess = do_new && !smatch_r;

  assign ram_we    = do_commit;
  assign ram_waddr = job_r.found ? idx_r : write_slot_r;
  assign ram_wdata = '{tag: job_r.item.tag, seq: job_r.item.seq,
                       codeword: job_r.item.codeword, pixels: job_r.item.pixels,
                       geo_gen: g1, cal_gen: c1};

  always_comb begin
    res.disp     = disp;
    res.geo_gen  = do_commit ? g1 : geo_cnt_r;
    res.cal_gen  = do_commit ? c1 : cal_cnt_r;
    res.tracked  = 4'(sess_cnt_r + SCW'(new_sess ? 1 : 0));
    res.retained = 7'(ret_cnt_r + RCW'((do_new && ret_cnt_r < RMAX) ? 1 : 0));
    if (do_clear) begin
      res = '{disp: DISP_CLEARED, geo_gen: '0, cal_gen: '0, tracked: '0, retained: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= B_IDLE;
      out_valid_r   <= 1'b0;
      valid_r       <= '0;
      conflict_r    <= '0;
      sess_active_r <= '0;
      write_slot_r  <= '0;
      geo_known_r   <= 1'b0;
      cal_known_r   <= 1'b0;
      geo_held_r    <= '0;
      cal_held_r    <= '0;
      geo_cnt_r     <= '0;
      cal_cnt_r     <= '0;
      sess_cnt_r    <= '0;
      ret_cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_APPLY) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_clear) begin
        valid_r       <= '0;
        conflict_r    <= '0;
        sess_active_r <= '0;
        write_slot_r  <= '0;
        geo_known_r   <= 1'b0;
        cal_known_r   <= 1'b0;
        geo_held_r    <= '0;
        cal_held_r    <= '0;
        geo_cnt_r     <= '0;
        cal_cnt_r     <= '0;
        sess_cnt_r    <= '0;
        ret_cnt_r     <= '0;
      end
      if (do_conf) begin
        conflict_r[idx_r] <= 1'b1;
      end
      if (do_commit) begin
        geo_cnt_r <= g1;
        cal_cnt_r <= c1;
        if (geo_ch) begin
          geo_known_r <= 1'b1;
          geo_held_r  <= job_r.item.geo;
        end
        if (cal_ch) begin
          cal_known_r <= 1'b1;
          cal_held_r  <= job_r.item.cal;
        end
      end
      if (do_new) begin
        valid_r[write_slot_r]    <= 1'b1;
        conflict_r[write_slot_r] <= 1'b0;
        write_slot_r <= (write_slot_r == LAST) ? '0 : write_slot_r + 1'b1;
        if (ret_cnt_r < RMAX) begin
          ret_cnt_r <= ret_cnt_r + 1'b1;
        end
      end
      if (new_sess) begin
        sess_active_r[eidx_r] <= 1'b1;
        sess_cnt_r <= sess_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      idx_r <= q_idx;
    end
    if (state_r == B_LOOK) begin
      smatch_r <= smatch;
      sfree_r  <= sfree;
      sidx_r   <= sidx;
      eidx_r   <= eidx;
    end
    if (state_r == B_APPLY) begin
      out_r <= res;
    end
    if (new_sess) begin
      sess_tag_r[eidx_r]  <= job_r.item.tag;
      sess_high_r[eidx_r] <= job_r.item.seq;
      sess_prof_r[eidx_r] <= job_r.item.profile;
    end else if (do_new) begin
      sess_high_r[sidx_r] <= job_r.item.seq;
    end
  end

`ifndef SYNTHESIS
  a_sess_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(sess_active_r) == int'(sess_cnt_r))
    else $error("session count out of step with active slots");
  a_ret_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ret_cnt_r <= RMAX)
    else $error("retained count above ring depth");
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    write_slot_r <= LAST)
    else $error("write slot beyond ring");
  a_pop_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_valid_r)
    else $error("job taken while a result waits");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/session_replay_dedup_admission.sv
// Top level of the session replay and duplicate admission filter.
//
//  channel  | dir | handshake          | payload
//  in_      | in  | in_tvalid/tready   | tdata: tag..calibration print, tuser: kind
//  out_     | out | out_tvalid/tready  | tdata: disposition..retained entries
//
// For an admit item the front scans the history RAM one entry a cycle through its single
// read port, stopping early on a match; the back then steps through a lookup state and
// an apply state for session lookup and update.
// Reset clears all valid bits at once; no clearing pass.
// The result register holds a result until taken while the next item is accepted.
`default_nettype none
module session_replay_dedup_admission #(
  parameter int HISTORY_DEPTH = srda_pkg::HISTORY_DEPTH_DEF,
  parameter int SESSION_SLOTS = srda_pkg::SESSION_SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // session_tag, frame_sequence, profile_id, codeword_print, pixel_print,
  // geometry_print, calibration_print
  input  wire logic [359:0] in_tdata,
  // kind
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // disposition, geometry_generation, calibration_generation, tracked_sessions,
  // retained_entries, zero pad
  output logic      [79:0]  out_tdata
);
  import srda_pkg::*;

  localparam int IW = $clog2(HISTORY_DEPTH);

  item_t         item;
  job_t          f_job, b_job;
  logic [IW-1:0] f_idx, b_idx, raddr, waddr;
  logic          push, q_full, q_empty, pop, back_busy, we;
  logic [HISTORY_DEPTH-1:0] hist_valid;
  hist_entry_t   rdata, wdata;
  result_t       res;

  assign item = '{clear: in_tuser, tag: in_tdata[63:0], seq: in_tdata[95:64],
                  profile: in_tdata[103:96], codeword: in_tdata[167:104],
                  pixels: in_tdata[231:168], geo: in_tdata[295:232],
                  cal: in_tdata[359:296]};

  assign out_tdata = {1'b0, res.retained, res.tracked, res.cal_gen, res.geo_gen, res.disp};

  srda_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item(item),
    .allow(q_empty && !back_busy), .hist_valid,
    .ram_raddr(raddr), .ram_rdata(rdata),
    .q_push(push), .q_job(f_job), .q_idx(f_idx), .q_full
  );

  srda_queue #(.IDX_W(IW)) u_queue (
    .clk, .rst_n,
    .push, .push_job(f_job), .push_idx(f_idx), .full(q_full), .empty(q_empty),
    .pop, .pop_job(b_job), .pop_idx(b_idx)
  );

  srda_ram #(.WIDTH($bits(hist_entry_t)), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  srda_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .SESSION_SLOTS(SESSION_SLOTS)) u_back (
    .clk, .rst_n,
    .q_empty, .q_pop(pop), .q_job(b_job), .q_idx(b_idx),
    .busy(back_busy), .hist_valid,
    .ram_we(we), .ram_waddr(waddr), .ram_wdata(wdata),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_result(res)
  );

endmodule
`default_nettype wire

FILE: tb/sv/session_replay_dedup_admission_tb.sv
// Self-checking testbench: replay and duplicate admission filter against a behavioural predictor.
module session_replay_dedup_admission_tb;
  import srda_pkg::*;

  localparam int HDEPTH = HISTORY_DEPTH_DEF;
  localparam int SLOTS  = SESSION_SLOTS_DEF;
  localparam int NTAGS  = 10;

  typedef struct {
    bit        kind;
    bit [63:0] tag;
    bit [31:0] seq;
    bit [7:0]  profile;
    bit [63:0] cw;
    bit [63:0] px;
    bit [63:0] geo;
    bit [63:0] cal;
  } obs_t;

  typedef struct {
    obs_t o;
    int   gap_pct;
    int   stall_pct;
    bit   drain;
  } pending_t;

  typedef struct {
    disp_t     disp;
    bit [31:0] geo_gen;
    bit [31:0] cal_gen;
    bit [3:0]  tracked;
    bit [6:0]  retained;
  } verdict_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [359:0] in_tdata = '0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [79:0]  out_tdata;

  session_replay_dedup_admission u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // predictor state
  bit        h_valid [HDEPTH];
  bit        h_conf  [HDEPTH];
  bit [63:0] h_tag   [HDEPTH];
  bit [31:0] h_seq   [HDEPTH];
  bit [63:0] h_cw    [HDEPTH];
  bit [63:0] h_px    [HDEPTH];
  bit [31:0] h_geo   [HDEPTH];
  bit [31:0] h_cal   [HDEPTH];
  bit        s_act   [SLOTS];
  bit [63:0] s_tag   [SLOTS];
  bit [31:0] s_hseq  [SLOTS];
  bit [7:0]  s_prof  [SLOTS];
  int        wr_slot, n_sess, n_ret;
  bit        geo_known, cal_known;
  bit [63:0] geo_held, cal_held;
  bit [31:0] geo_gen, cal_gen;

  function void wipe_tables();
    for (int i = 0; i < HDEPTH; i++) begin
      h_valid[i] = 0;
      h_conf[i] = 0;
    end
    for (int i = 0; i < SLOTS; i++) s_act[i] = 0;
    wr_slot = 0; n_sess = 0; n_ret = 0;
    geo_known = 0; cal_known = 0; geo_held = 0; cal_held = 0;
    geo_gen = 0; cal_gen = 0;
  endfunction

  function verdict_t report(disp_t d);
    verdict_t v;
    v.disp = d;
    v.geo_gen = geo_gen;
    v.cal_gen = cal_gen;
    v.tracked = n_sess[3:0];
    v.retained = n_ret[6:0];
    return v;
  endfunction

  function verdict_t admit(obs_t o);
    int  hit, sess, free_slot, k;
    bit  geo_chg, cal_chg;
    disp_t d;
    hit = -1; sess = -1; free_slot = -1;
    if (o.kind) begin
      wipe_tables();
      return report(DISP_CLEARED);
    end
    for (int i = 0; i < HDEPTH; i++)
      if (hit < 0 && h_valid[i] && h_tag[i] == o.tag && h_seq[i] == o.seq) hit = i;
    if (hit >= 0 && (h_conf[hit] || h_cw[hit] != o.cw)) begin
      h_conf[hit] = 1;
      return report(DISP_CONFLICT);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (s_act[i] && s_tag[i] == o.tag) sess = i;
      if (!s_act[i] && free_slot < 0) free_slot = i;
    end
    if (sess < 0 && free_slot < 0) return report(DISP_SESSION_LIMIT);
    if (sess >= 0 && s_prof[sess] != o.profile) return report(DISP_CONFLICT);
    if (hit < 0 && sess >= 0 && o.seq <= s_hseq[sess]) return report(DISP_STALE);
    geo_chg = !geo_known || geo_held != o.geo;
    cal_chg = !cal_known || cal_held != o.cal;
    if ((geo_chg && geo_gen == GEN_MAX) || (cal_chg && cal_gen == GEN_MAX))
      return report(DISP_EXHAUSTED);
    if (geo_chg) begin
      geo_gen++; geo_known = 1; geo_held = o.geo;
    end
    if (cal_chg) begin
      cal_gen++; cal_known = 1; cal_held = o.cal;
    end
    if (hit >= 0) begin
      if (h_geo[hit] != geo_gen) d = DISP_DUP_GEOMETRY;
      else if (h_cal[hit] != cal_gen) d = DISP_DUP_CALIBRATION;
      else if (h_px[hit] == o.px) d = DISP_DUP_PIXELS;
      else d = DISP_DUP_OBSERVATION;
      h_px[hit] = o.px; h_geo[hit] = geo_gen; h_cal[hit] = cal_gen;
      return report(d);
    end
    if (sess < 0) begin
      s_act[free_slot] = 1; s_tag[free_slot] = o.tag;
      s_hseq[free_slot] = o.seq; s_prof[free_slot] = o.profile;
      n_sess++;
    end else begin
      s_hseq[sess] = o.seq;
    end
    k = wr_slot;
    h_valid[k] = 1; h_conf[k] = 0; h_tag[k] = o.tag; h_seq[k] = o.seq;
    h_cw[k] = o.cw; h_px[k] = o.px; h_geo[k] = geo_gen; h_cal[k] = cal_gen;
    wr_slot = (k + 1) % HDEPTH;
    if (n_ret < HDEPTH) n_ret++;
    return report(DISP_ACCEPTED);
  endfunction

  pending_t pending_q[$];
  verdict_t verdict_q[$];
  obs_t     cur_obs;
  bit       in_taken;
  int       stall_pct, hold_left, accepted_n, mismatches;
  bit       hold_done;

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_tvalid && !in_taken)) begin
        in_taken = 0;
        if (pending_q.size() == 0 || $urandom_range(0, 99) < pending_q[0].gap_pct ||
            (pending_q[0].drain && verdict_q.size() != 0)) begin
          in_tvalid <= 0;
        end else begin
          pending_t p;
          p = pending_q.pop_front();
          cur_obs = p.o;
          stall_pct = p.stall_pct;
          in_tdata <= {p.o.cal, p.o.geo, p.o.px, p.o.cw, p.o.profile, p.o.seq, p.o.tag};
          in_tuser <= p.o.kind;
          in_tvalid <= 1;
        end
      end
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (accepted_n >= 400 && !hold_done) begin
        hold_left <= 600;
        hold_done <= 1;
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        verdict_t e;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %h", out_tdata);
        end else begin
          e = verdict_q.pop_front();
          if (out_tdata[3:0] != e.disp || out_tdata[35:4] != e.geo_gen ||
              out_tdata[67:36] != e.cal_gen || out_tdata[71:68] != e.tracked ||
              out_tdata[78:72] != e.retained) begin
            mismatches++;
            if (mismatches <= 10)
              $display("exp disp %0d geo %0d cal %0d sess %0d ret %0d / got %0d %0d %0d %0d %0d",
                       e.disp, e.geo_gen, e.cal_gen, e.tracked, e.retained,
                       out_tdata[3:0], out_tdata[35:4], out_tdata[67:36],
                       out_tdata[71:68], out_tdata[78:72]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        verdict_q.push_back(admit(cur_obs));
        in_taken = 1;
        accepted_n++;
      end
    end
  end

  obs_t      recent_q[$];
  bit [63:0] tags [NTAGS];
  bit [7:0]  profs [NTAGS];
  bit [31:0] last_seq [NTAGS];
  bit [63:0] geo_pool [3];
  bit [63:0] cal_pool [3];
  int        n_queued;

  function obs_t rnd64_obs();
    obs_t o;
    o.kind = 0;
    o.tag = {$urandom, $urandom}; o.seq = $urandom; o.profile = 8'($urandom);
    o.cw = {$urandom, $urandom}; o.px = {$urandom, $urandom};
    o.geo = {$urandom, $urandom}; o.cal = {$urandom, $urandom};
    return o;
  endfunction

  function void enqueue(obs_t o, bit drain);
    pending_t p;
    int ph;
    ph = (n_queued / 150) % 4;
    p.o = o;
    p.drain = drain;
    p.gap_pct = (ph == 1) ? 80 : (ph == 3) ? 22 : 0;
    p.stall_pct = (ph == 2) ? 80 : (ph == 3) ? 22 : 0;
    pending_q.push_back(p);
    n_queued++;
    if (!o.kind) begin
      recent_q.push_back(o);
      if (recent_q.size() > 80) void'(recent_q.pop_front());
    end
  endfunction

  function obs_t next_random();
    obs_t o;
    int r, t, s;
    r = $urandom_range(0, 99);
    o = rnd64_obs();
    if (r < 2) begin
      o.kind = 1;
    end else if (r < 6) begin
      o.kind = 0;
    end else if (r < 32 && recent_q.size() > 0) begin
      o = recent_q[$urandom_range(0, recent_q.size() - 1)];
      s = $urandom_range(0, 99);
      if (s >= 40 && s < 60) o.px = {$urandom, $urandom};
      else if (s >= 60 && s < 72) o.cw = {$urandom, $urandom};
      else if (s >= 72 && s < 80) o.profile = 8'($urandom);
      if ($urandom_range(0, 3) == 0) o.geo = geo_pool[$urandom_range(0, 2)];
      if ($urandom_range(0, 3) == 0) o.cal = cal_pool[$urandom_range(0, 2)];
    end else begin
      t = $urandom_range(0, NTAGS - 1);
      s = $urandom_range(0, 99);
      o.tag = tags[t];
      if (s < 85) o.seq = last_seq[t] + $urandom_range(1, 4);
      else if (s < 95) o.seq = last_seq[t] - $urandom_range(0, 3);
      last_seq[t] = o.seq;
      o.profile = ($urandom_range(0, 19) == 0) ? 8'($urandom) : profs[t];
      o.geo = geo_pool[$urandom_range(0, 2)];
      o.cal = cal_pool[$urandom_range(0, 2)];
      if ($urandom_range(0, 49) == 0) geo_pool[$urandom_range(0, 2)] = {$urandom, $urandom};
      if ($urandom_range(0, 49) == 0) cal_pool[$urandom_range(0, 2)] = {$urandom, $urandom};
    end
    return o;
  endfunction

  initial begin
    obs_t o, base;
    wipe_tables();
    for (int i = 0; i < NTAGS; i++) begin
      tags[i] = {$urandom, $urandom}; profs[i] = 8'($urandom); last_seq[i] = $urandom;
    end
    for (int i = 0; i < 3; i++) begin
      geo_pool[i] = {$urandom, $urandom}; cal_pool[i] = {$urandom, $urandom};
    end
    o = rnd64_obs(); o.kind = 1;
    enqueue(o, 0);
    o = '{0, '0, '0, '0, '0, '0, '0, '0};
    enqueue(o, 0);
    base = '{0, '1, '1, '1, '1, '1, '1, '1};
    enqueue(base, 0);
    enqueue(base, 0);
    o = base; o.px = 64'h0;
    enqueue(o, 0);
    o.geo = 64'h0;
    enqueue(o, 0);
    o.cal = 64'h0;
    enqueue(o, 0);
    o.cw = 64'h0;
    enqueue(o, 0);
    enqueue(base, 0);
    o = base; o.seq = 32'h0; o.profile = 8'h7f;
    enqueue(o, 0);
    o = '{0, '0, 32'h0, '0, '0, '0, '0, '0};
    enqueue(o, 0);
    for (int i = 0; i < 8; i++) begin
      o = rnd64_obs();
      enqueue(o, 0);
    end
    o = rnd64_obs(); o.kind = 1;
    enqueue(o, 0);
    while (n_queued < 1820) enqueue(next_random(), (n_queued % 700) == 699);

    repeat (5) @(posedge clk);
    rst_n <= 1;
    while (pending_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
